### design/bdlp_pkg.sv
// bdlp_pkg: shared types and constants for the button debouncer with long press
// holds opcode codes, field widths and the per-button control and status structs
// no dependencies
package bdlp_pkg;

    // field widths
    localparam int OPCODE_WIDTH = 2;
    localparam int RAW_WIDTH    = 3;
    localparam int INDEX_WIDTH  = 2;
    localparam int HOLD_WIDTH   = 16;

    // long press tick count after reset
    localparam logic [HOLD_WIDTH-1:0] LONG_PRESS_RESET = 16'd100;

    // opcodes; the fourth code means nothing and is dropped
    localparam logic [OPCODE_WIDTH-1:0] OP_TICK        = 2'd0;
    localparam logic [OPCODE_WIDTH-1:0] OP_QUERY_PRESS = 2'd1;
    localparam logic [OPCODE_WIDTH-1:0] OP_QUERY_LONG  = 2'd2;

    typedef logic [HOLD_WIDTH-1:0] hold_t;

    // control into one button cell
    typedef struct packed {
        logic tick;          // sample tick this cycle
        logic level;         // raw pin level, 0 = pressed
        logic clear_report;  // press report read, disarm it
    } btn_ctrl_t;

    // status out of one button cell
    typedef struct packed {
        logic report_ready;  // pressed latch low and report armed
        logic long_flag;     // press held long enough
    } btn_status_t;

endpackage

### design/button_debounce_long_press.sv
// button_debounce_long_press: top level, input register, button cells, result register
// queries pass the input register, then the result register, which holds while
// m_ready is low; one word per cycle unless a query waits on a held result
// reset: synchronous active-low aresetn clears all button state, both valid flags,
// and sets long_press_ticks to 100
module button_debounce_long_press
    import bdlp_pkg::*;
#(
    parameter int BUTTON_COUNT = 3
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // input words
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OPCODE_WIDTH-1:0] s_opcode,
    input  logic [RAW_WIDTH-1:0]    s_raw_levels,
    input  logic [INDEX_WIDTH-1:0]  s_button_index,
    // result words
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_answer,
    // configuration
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  hold_t                   cfg_data
);

    logic                    in_valid_reg, in_valid_next;
    logic [OPCODE_WIDTH-1:0] op_reg;
    logic [RAW_WIDTH-1:0]    raw_reg;
    logic [INDEX_WIDTH-1:0]  idx_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    answer_reg;
    hold_t                   ticks_reg, ticks_next;
    logic                    is_query, advance;
    logic [BUTTON_COUNT-1:0] hit, report_vec, long_vec;
    logic                    answer_next;

    // configuration register, always ready
    assign cfg_ready  = 1'b1;
    assign ticks_next = (cfg_valid) ? cfg_data : ticks_reg;

    // held word leaves when it has no result or the result register frees up
    assign is_query = (op_reg == OP_QUERY_PRESS) || (op_reg == OP_QUERY_LONG);
    assign advance  = in_valid_reg && (!is_query || !out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;

    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign out_valid_next = (advance && is_query) || (out_valid_reg && !m_ready);

    // per-button cells
    for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_btn
        btn_ctrl_t   ctrl;
        btn_status_t status;
        logic        level;

        // buttons beyond the pin field read as pressed
        if (b < RAW_WIDTH) begin : g_pin
            assign level = raw_reg[b];
        end else begin : g_nopin
            assign level = 1'b0;
        end

        assign hit[b]            = (32'(idx_reg) == b);
        assign ctrl.tick         = advance && (op_reg == OP_TICK);
        assign ctrl.level        = level;
        assign ctrl.clear_report = advance && (op_reg == OP_QUERY_PRESS) && hit[b];

        bdlp_button u_button (
            .aclk             (aclk),
            .aresetn          (aresetn),
            .ctrl             (ctrl),
            .long_press_ticks (ticks_reg),
            .status           (status)
        );

        assign report_vec[b] = status.report_ready;
        assign long_vec[b]   = status.long_flag;
    end

    // answer select; an out-of-range index hits no button and reads 0
    always_comb begin
        answer_next = answer_reg;
        if (advance) begin
            priority if (op_reg == OP_QUERY_PRESS) begin
                answer_next = |(hit & report_vec);
            end else if (op_reg == OP_QUERY_LONG) begin
                answer_next = |(hit & long_vec);
            end else begin
                answer_next = answer_reg;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ticks_reg     <= LONG_PRESS_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            ticks_reg     <= ticks_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_opcode;
            raw_reg <= s_raw_levels;
            idx_reg <= s_button_index;
        end
        answer_reg <= answer_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_answer = answer_reg;

endmodule

### design/bdlp_button.sv
// bdlp_button: debounce and long-press state of one button
// three-sample history, stable level, press report and saturating hold counter
// depends on bdlp_pkg
module bdlp_button
    import bdlp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  btn_ctrl_t   ctrl,
    input  hold_t       long_press_ticks,
    output btn_status_t status
);

    logic  newest_reg, middle_reg;
    logic  newest_next, middle_next;
    logic  stable_reg, stable_next;
    logic  latch_reg, latch_next;
    logic  armed_reg, armed_next;
    logic  long_reg, long_next;
    hold_t hold_reg, hold_next;
    hold_t hold_dec;
    logic  agree;

    // counter decremented with saturation at zero
    assign hold_dec = (hold_reg != '0) ? hold_reg - hold_t'(1) : '0;

    // history agrees once all three samples after the shift match;
    // the oldest sample after the shift is middle_reg, so it needs no register
    assign agree = (middle_reg == newest_reg) && (newest_reg == ctrl.level);

    // next state of one tick or a report read
    always_comb begin
        newest_next = newest_reg;
        middle_next = middle_reg;
        stable_next = stable_reg;
        latch_next  = latch_reg;
        armed_next  = armed_reg;
        long_next   = long_reg;
        hold_next   = hold_reg;
        if (ctrl.tick) begin
            newest_next = ctrl.level;
            middle_next = newest_reg;
            if (agree) begin
                if (stable_reg != middle_reg) begin
                    stable_next = middle_reg;
                    if (!middle_reg) begin
                        // new stable press
                        latch_next = 1'b0;
                        hold_next  = long_press_ticks;
                    end else begin
                        // new stable release
                        latch_next = 1'b1;
                        long_next  = 1'b0;
                        armed_next = 1'b1;
                    end
                end else if (!stable_reg) begin
                    // press still held
                    hold_next = hold_dec;
                    if (hold_dec == '0) begin
                        long_next = 1'b1;
                    end
                end
            end
        end else if (ctrl.clear_report && !latch_reg) begin
            // report given only while the latch shows a press
            armed_next = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newest_reg <= 1'b0;
            middle_reg <= 1'b0;
            stable_reg <= 1'b0;
            latch_reg  <= 1'b0;
            armed_reg  <= 1'b0;
            long_reg   <= 1'b0;
            hold_reg   <= '0;
        end else begin
            newest_reg <= newest_next;
            middle_reg <= middle_next;
            stable_reg <= stable_next;
            latch_reg  <= latch_next;
            armed_reg  <= armed_next;
            long_reg   <= long_next;
            hold_reg   <= hold_next;
        end
    end

    // status to the answer select
    assign status.report_ready = !latch_reg && armed_reg;
    assign status.long_flag    = long_reg;

endmodule

### tb/sv/tb_button_debounce_long_press.sv
// tb_button_debounce_long_press: self-checking bench for the three-button debouncer
// tracks debounce, hold countdown and press report state per button and checks every answer word
// depends on bdlp_pkg and button_debounce_long_press
`timescale 1ns / 100ps

module tb_button_debounce_long_press;
    import bdlp_pkg::*;

    localparam int NUM_BUTTONS = 3;
    localparam int STALL_LIMIT = 2000;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [OPCODE_WIDTH-1:0] OP_UNUSED = 2'd3;

    // debounce state tracker and queue of answers still owed by the block
    class debounce_scoreboard;
        bit [NUM_BUTTONS-1:0] newest, middle, oldest;
        bit [NUM_BUTTONS-1:0] stable_lvl, latch, armed, long_set;
        hold_t hold_left [NUM_BUTTONS];
        hold_t long_ticks;
        bit answers_due [$];
        int errors;
        int checked;
        int words_taken;

        function new();
            newest = '0;
            middle = '0;
            oldest = '0;
            stable_lvl = '0;
            latch = '0;
            armed = '0;
            long_set = '0;
            foreach (hold_left[b]) hold_left[b] = '0;
            long_ticks = LONG_PRESS_RESET;
            errors = 0;
            checked = 0;
            words_taken = 0;
        endfunction

        // one sample tick on every button
        function void sample_tick(logic [RAW_WIDTH-1:0] raw);
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                oldest[b] = middle[b];
                middle[b] = newest[b];
                newest[b] = (b < RAW_WIDTH) ? raw[b] : 1'b0;
                if (oldest[b] == middle[b] && middle[b] == newest[b]) begin
                    if (stable_lvl[b] != oldest[b]) begin
                        stable_lvl[b] = oldest[b];
                        if (!stable_lvl[b]) begin
                            // new stable press
                            latch[b] = 1'b0;
                            hold_left[b] = long_ticks;
                        end else begin
                            // new stable release
                            latch[b] = 1'b1;
                            long_set[b] = 1'b0;
                            armed[b] = 1'b1;
                        end
                    end else if (!stable_lvl[b]) begin
                        // held press, count down and saturate at zero
                        if (hold_left[b] != '0) hold_left[b] = hold_left[b] - 1'b1;
                        if (hold_left[b] == '0) long_set[b] = 1'b1;
                    end
                end
            end
        endfunction

        // accepted input word
        function void note_word(logic [OPCODE_WIDTH-1:0] op, logic [RAW_WIDTH-1:0] raw,
                                logic [INDEX_WIDTH-1:0] idx);
            bit ans;
            ans = 1'b0;
            if (op != OP_UNUSED) words_taken++;
            case (op)
                OP_TICK: sample_tick(raw);
                OP_QUERY_PRESS: begin
                    if (idx < NUM_BUTTONS && !latch[idx] && armed[idx]) begin
                        armed[idx] = 1'b0;
                        ans = 1'b1;
                    end
                    answers_due.push_back(ans);
                end
                OP_QUERY_LONG: begin
                    if (idx < NUM_BUTTONS) ans = long_set[idx];
                    answers_due.push_back(ans);
                end
                default: ;
            endcase
        endfunction

        // accepted result word against the oldest expectation
        function void check_answer(logic ans);
            bit want;
            if (answers_due.size() == 0) begin
                errors++;
                $display("%0t: answer word with none expected, expected none actual %0b",
                         $time, ans);
                return;
            end
            want = answers_due.pop_front();
            checked++;
            if (ans !== want) begin
                errors++;
                $display("%0t: answer mismatch, expected %0b actual %0b", $time, want, ans);
            end
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [OPCODE_WIDTH-1:0] s_opcode;
    logic [RAW_WIDTH-1:0]    s_raw_levels;
    logic [INDEX_WIDTH-1:0]  s_button_index;
    logic                    m_valid;
    logic                    m_ready;
    logic                    m_answer;
    logic                    cfg_valid;
    logic                    cfg_ready;
    hold_t                   cfg_data;

    debounce_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    int settings_used;

    button_debounce_long_press #(
        .BUTTON_COUNT(NUM_BUTTONS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_raw_levels  (s_raw_levels),
        .s_button_index(s_button_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_answer      (m_answer),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // receiver stalls
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // answer word monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_answer(m_answer);
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // drive one input word, with random sender gaps ahead of it
    task automatic send_word(input logic [OPCODE_WIDTH-1:0] op,
                             input logic [RAW_WIDTH-1:0] raw,
                             input logic [INDEX_WIDTH-1:0] idx);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_raw_levels <= raw;
        s_button_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(op, raw, idx);
    endtask

    // stop sending and let every owed answer come back
    task automatic drain_answers();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.answers_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // write long_press_ticks while the block is idle
    task automatic write_long_ticks(input hold_t value);
        drain_answers();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.long_ticks = value;
        settings_used++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // press and release runs with bounce, mixed with queries and some noise
    task automatic random_words(input int count, input int hold_span);
        logic [RAW_WIDTH-1:0] target;
        logic [RAW_WIDTH-1:0] raw;
        int run_left;
        int done;
        int pick;
        target = RAW_WIDTH'($urandom_range(7));
        run_left = $urandom_range(1, 2 * hold_span + 6);
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                send_word(OP_UNUSED, RAW_WIDTH'($urandom), INDEX_WIDTH'($urandom));
            end else if (pick < 10) begin
                send_word(OP_TICK, RAW_WIDTH'($urandom), INDEX_WIDTH'($urandom));
                done++;
            end else if (pick < 42) begin
                send_word((pick < 26) ? OP_QUERY_PRESS : OP_QUERY_LONG,
                          RAW_WIDTH'($urandom), INDEX_WIDTH'($urandom));
                done++;
            end else begin
                if (run_left == 0) begin
                    target = target ^ RAW_WIDTH'($urandom_range(1, 7));
                    run_left = $urandom_range(1, 2 * hold_span + 6);
                end
                raw = target;
                if ($urandom_range(99) < 8) raw = raw ^ RAW_WIDTH'(1 << $urandom_range(2));
                send_word(OP_TICK, raw, INDEX_WIDTH'($urandom));
                run_left--;
                done++;
            end
        end
    endtask

    // main sequence
    initial begin
        hold_t settings [6];
        int per_phase;
        int span;
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_opcode = OP_TICK;
        s_raw_levels = '0;
        s_button_index = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet_cycles = 0;
        settings_used = 0;
        send_idle_pct = 16;
        recv_idle_pct = 48;
        settings = '{16'd1, 16'hFFFF, 16'd0, 16'd5, 16'd12, hold_t'($urandom_range(2, 40))};
        per_phase = 275;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: out of range index, press held from reset, ignored opcode,
        // release then press, report read twice, bounce on every bit
        send_word(OP_QUERY_PRESS, 3'd0, 2'd0);
        send_word(OP_QUERY_LONG, 3'd7, 2'd3);
        send_word(OP_TICK, 3'd0, 2'd0);
        send_word(OP_QUERY_LONG, 3'd0, 2'd0);
        send_word(OP_QUERY_LONG, 3'd0, 2'd1);
        send_word(OP_UNUSED, 3'd7, 2'd2);
        repeat (3) send_word(OP_TICK, 3'd7, 2'd3);
        send_word(OP_QUERY_LONG, 3'd0, 2'd2);
        send_word(OP_QUERY_PRESS, 3'd0, 2'd1);
        repeat (3) send_word(OP_TICK, 3'd0, 2'd0);
        send_word(OP_QUERY_PRESS, 3'd0, 2'd0);
        send_word(OP_QUERY_PRESS, 3'd0, 2'd1);
        send_word(OP_QUERY_PRESS, 3'd0, 2'd2);
        send_word(OP_QUERY_PRESS, 3'd0, 2'd3);
        send_word(OP_QUERY_PRESS, 3'd0, 2'd0);
        send_word(OP_TICK, 3'd5, 2'd0);
        send_word(OP_TICK, 3'd2, 2'd0);
        send_word(OP_QUERY_LONG, 3'd0, 2'd0);

        // random phases over several long press settings
        foreach (settings[p]) begin
            if (p < 2) begin
                send_idle_pct = 16;
                recv_idle_pct = 48;
            end else if (p < 4) begin
                send_idle_pct = 48;
                recv_idle_pct = 16;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_long_ticks(settings[p]);
            span = (settings[p] > 30) ? 30 : int'(settings[p]);
            if (p == 3) begin
                // sender holds off mid phase until all answers are back
                random_words(per_phase / 2, span);
                drain_answers();
                random_words(per_phase - per_phase / 2, span);
            end else begin
                random_words(per_phase, span);
            end
        end

        drain_answers();
        repeat (8) @(posedge aclk);
        $display("covered %0d words and checked %0d answers over %0d long press settings,",
                 sb.words_taken, sb.checked, settings_used);
        $display("with bounce, out of range queries and sender and receiver stalls");
        if (sb.errors == 0 && sb.answers_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
